// File: design/page_replacement_fifo_lru_assert.svh
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru_assert.svh
// Assertion macros used by the page replacement sequencer.
// ----------------------------------------------------------------------------
`ifndef PAGE_REPLACEMENT_FIFO_LRU_ASSERT_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property that must hold at every clock edge outside reset
`define PRFL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// antecedent this cycle implies consequent in the next cycle
`define PRFL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PRFL_ASSERT(lbl, prop, msg)
`define PRFL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/prfl_pkg.sv
// ----------------------------------------------------------------------------
// prfl_pkg
// Types and constants of the page replacement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prfl_pkg;

	// field widths
	localparam int PAGE_BITS    = 8;
	localparam int COUNT_W      = 16;
	localparam int SLOT_FIELD_W = 3;
	localparam int FRAMES_W     = 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// register indexes (address bit 2)
	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_FRAMES = 1'b1;

	// register reset values
	localparam logic                POLICY_RESET = 1'b1;
	localparam logic [FRAMES_W-1:0] FRAMES_RESET = 4'd3;

	// policy codes
	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	typedef struct packed {
		logic [PAGE_BITS-1:0] page_number;
		logic                 restart;
	} prfl_req_t;

	typedef struct packed {
		logic                    fault;
		logic [SLOT_FIELD_W-1:0] hit_slot;
		logic                    evicted_valid;
		logic [PAGE_BITS-1:0]    evicted_page;
		logic [COUNT_W-1:0]      fault_total;
	} prfl_rsp_t;

	typedef struct packed {
		logic                policy_mode;
		logic [FRAMES_W-1:0] frames_in_use;
	} prfl_cfg_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} prfl_cmd_t;

endpackage

// File: design/prfl_regs.sv
// ----------------------------------------------------------------------------
// prfl_regs
// APB configuration registers: replacement policy and frame count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prfl_regs import prfl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output prfl_cfg_t   cfg
);

	logic                policy_q;
	logic [FRAMES_W-1:0] frames_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_RESET;
			frames_q <= FRAMES_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_POLICY: policy_q <= pwdata[0];
				REG_FRAMES: frames_q <= pwdata[FRAMES_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[2])
			REG_POLICY: prdata = {31'b0, policy_q};
			REG_FRAMES: prdata = {{(32-FRAMES_W){1'b0}}, frames_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.policy_mode   = policy_q;
	assign cfg.frames_in_use = frames_q;

endmodule

// File: design/prfl_datapath.sv
// ----------------------------------------------------------------------------
// prfl_datapath
// Frame list, parallel search, list shift, fault counter and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prfl_datapath import prfl_pkg::*; #(
	parameter int MAX_FRAMES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  prfl_cmd_t cmd,
	input  prfl_cfg_t cfg,
	input  prfl_req_t req,
	output prfl_rsp_t rsp
);

	localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam logic [7:0] MAXF8 = 8'(MAX_FRAMES);

	prfl_req_t            req_q;
	prfl_rsp_t            rsp_q;
	logic [PAGE_BITS-1:0] page_q [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] valid_q;
	logic [COUNT_W-1:0]   cnt_q;

	logic [7:0]            fiu8, n8, last8;
	logic [SLOT_W-1:0]     last_idx, slot, sh_last;
	logic [SLOT_W+2:0]     slot_ext;
	logic [MAX_FRAMES-1:0] valid_eff;
	logic                  found, do_shift, ev_valid;
	logic [COUNT_W-1:0]    cnt_base, cnt_next;

	// clamp frame count to 1..MAX_FRAMES
	always_comb begin
		fiu8 = {{(8-FRAMES_W){1'b0}}, cfg.frames_in_use};
		if (fiu8 == 8'd0)
			n8 = 8'd1;
		else if (fiu8 > MAXF8)
			n8 = MAXF8;
		else
			n8 = fiu8;
		last8    = n8 - 8'd1;
		last_idx = last8[SLOT_W-1:0];
	end

	// restart clears the list and count ahead of the lookup
	assign valid_eff = req_q.restart ? '0 : valid_q;
	assign cnt_base  = req_q.restart ? '0 : cnt_q;

	// compare all in-use frames, highest matching position wins
	always_comb begin
		found = 1'b0;
		slot  = '0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			if (valid_eff[i] && (page_q[i] == req_q.page_number) &&
			    (SLOT_W'(i) <= last_idx)) begin
				found = 1'b1;
				slot  = SLOT_W'(i);
			end
		end
	end

	assign ev_valid = !found && valid_eff[last_idx];
	assign do_shift = !found || (cfg.policy_mode == POLICY_LRU);
	assign sh_last  = found ? slot : last_idx;
	assign slot_ext = {3'b000, slot};
	assign cnt_next = (!found && (cnt_base != COUNT_MAX)) ? cnt_base + 1'b1 : cnt_base;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture)
			req_q <= req;
	end

	// frame pages: shift back and insert at the front
	always_ff @(posedge clk) begin
		if (cmd.exec && do_shift) begin
			page_q[0] <= req_q.page_number;
			for (int i = 1; i < MAX_FRAMES; i++) begin
				if (SLOT_W'(i) <= sh_last)
					page_q[i] <= page_q[i-1];
			end
		end
	end

	// valid bits and fault counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.exec) begin
			cnt_q <= cnt_next;
			if (do_shift) begin
				valid_q[0] <= 1'b1;
				for (int i = 1; i < MAX_FRAMES; i++) begin
					if (SLOT_W'(i) <= sh_last)
						valid_q[i] <= valid_eff[i-1];
					else
						valid_q[i] <= valid_eff[i];
				end
			end else begin
				valid_q <= valid_eff;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.fault         <= !found;
			rsp_q.hit_slot      <= found ? slot_ext[2:0] : '0;
			rsp_q.evicted_valid <= ev_valid;
			rsp_q.evicted_page  <= ev_valid ? page_q[last_idx] : '0;
			rsp_q.fault_total   <= cnt_next;
		end
	end

	assign rsp = rsp_q;

endmodule

// File: design/prfl_ctrl.sv
// ----------------------------------------------------------------------------
// prfl_ctrl
// Sequencer: accepts a reference, runs the execute state, strobes the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_replacement_fifo_lru_assert.svh"

module prfl_ctrl import prfl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output prfl_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
						busy_q  <= 1'b1;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign cmd.capture = start && !busy_q;
	assign cmd.exec    = (state_q == ST_EXEC);

	// sequencing checks
	`PRFL_ASSERT_NEXT(a_accept_execs, start && !busy, cmd.exec, "accepted transaction not executed")
	`PRFL_ASSERT_NEXT(a_exec_done, cmd.exec, done && !busy, "execute cycle gave no strobe")
	`PRFL_ASSERT(a_busy_exec, busy == cmd.exec, "busy out of step with execute state")
	`PRFL_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")

endmodule

// File: design/page_replacement_fifo_lru.sv
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru
// Page replacement unit with FIFO or LRU policy over a list of page frames.
// ----------------------------------------------------------------------------
// A reference is taken when start is high and busy is low. The next cycle
// compares every in-use frame in parallel and shifts the list, and the result
// appears on result with done high for exactly one cycle after that. There is
// no backpressure on the result side: done is a single-cycle strobe and the
// receiver must capture result in that cycle. busy is high only during the
// execute cycle, so a new reference may be started in the cycle done shows,
// and none is taken while one executes. Configuration writes go through the
// APB port and are to be made only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_replacement_fifo_lru import prfl_pkg::*; #(
	parameter int MAX_FRAMES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  prfl_req_t   request,
	output logic        done,
	output prfl_rsp_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	prfl_cfg_t cfg;
	prfl_cmd_t cmd;

	// configuration registers
	prfl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	prfl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// frame list datapath
	prfl_datapath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.req    (request),
		.rsp    (result)
	);

endmodule

// File: tb/page_replacement_fifo_lru_tb.sv
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru_tb
// Self-checking bench for the FIFO / LRU page replacement unit. References
// go in through the start / busy command port and every result strobe is
// checked field by field against a predictor that tracks the frame list,
// fault count and register settings. Directed sequences cover both
// policies, frame count limits and stale duplicate pages. Random traffic
// then runs over a rotating set of settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_replacement_fifo_lru_tb;
	import prfl_pkg::*;

	localparam int FRAME_SLOTS = 8;
	localparam int STALL_LIMIT = 1000;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #6 clk = ~clk;

	// block ports
	logic        start = 1'b0;
	logic        busy;
	prfl_req_t   request = '0;
	logic        done;
	prfl_rsp_t   result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	page_replacement_fifo_lru #(
		.MAX_FRAMES(FRAME_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predicted frame list and register copies
	logic [PAGE_BITS-1:0] resident_page [FRAME_SLOTS] = '{default: '0};
	logic                 resident_valid [FRAME_SLOTS] = '{default: 1'b0};
	logic [COUNT_W-1:0]   fault_tally = '0;
	logic                 policy_shadow = POLICY_RESET;
	logic [FRAMES_W-1:0]  frame_count_shadow = FRAMES_RESET;

	prfl_rsp_t expected_results [$];
	int        error_count = 0;
	int        sender_idle_pct = 0;
	int        quiet_cycles = 0;

	task automatic flag_error(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR at %0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// move positions 0..last-1 back by one and put the page in front
	function automatic void shift_in(input int last, input logic [PAGE_BITS-1:0] page);
		int i;
		for (i = last; i > 0; i--) begin
			resident_page[i] = resident_page[i-1];
			resident_valid[i] = resident_valid[i-1];
		end
		resident_page[0] = page;
		resident_valid[0] = 1'b1;
	endfunction

	// apply one reference to the predicted list and return its result
	function automatic prfl_rsp_t replace_page(input prfl_req_t req);
		int        used;
		int        slot;
		int        i;
		logic      found;
		prfl_rsp_t rsp;
		if (req.restart) begin
			for (i = 0; i < FRAME_SLOTS; i++)
				resident_valid[i] = 1'b0;
			fault_tally = '0;
		end
		used = frame_count_shadow;
		if (used < 1)
			used = 1;
		if (used > FRAME_SLOTS)
			used = FRAME_SLOTS;
		// deepest matching position wins
		found = 1'b0;
		slot = 0;
		for (i = 0; i < used; i++) begin
			if (resident_valid[i] && resident_page[i] == req.page_number) begin
				found = 1'b1;
				slot = i;
			end
		end
		rsp = '0;
		if (!found) begin
			rsp.fault = 1'b1;
			if (resident_valid[used-1]) begin
				rsp.evicted_valid = 1'b1;
				rsp.evicted_page = resident_page[used-1];
			end
			shift_in(used - 1, req.page_number);
			if (fault_tally != COUNT_MAX)
				fault_tally++;
			slot = 0;
		end else if (policy_shadow == POLICY_LRU) begin
			shift_in(slot, req.page_number);
		end
		rsp.hit_slot = SLOT_FIELD_W'(slot);
		rsp.fault_total = fault_tally;
		return rsp;
	endfunction

	// check each result strobe, then record each accepted transaction
	always @(posedge clk) begin : check_results
		prfl_rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					flag_error("result with no transaction pending",
						32'(result.fault_total), '0);
				end else begin
					want = expected_results.pop_front();
					if (result.fault !== want.fault)
						flag_error("fault", 32'(result.fault), 32'(want.fault));
					if (result.hit_slot !== want.hit_slot)
						flag_error("hit_slot", 32'(result.hit_slot), 32'(want.hit_slot));
					if (result.evicted_valid !== want.evicted_valid)
						flag_error("evicted_valid", 32'(result.evicted_valid),
							32'(want.evicted_valid));
					if (result.evicted_page !== want.evicted_page)
						flag_error("evicted_page", 32'(result.evicted_page),
							32'(want.evicted_page));
					if (result.fault_total !== want.fault_total)
						flag_error("fault_total", 32'(result.fault_total),
							32'(want.fault_total));
				end
			end
			if (start && !busy)
				expected_results.push_back(replace_page(request));
		end
	end

	// watchdog on cycles with no transaction in either direction
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// send one reference, at times with a random gap in front of it
	task automatic send_reference(input logic [PAGE_BITS-1:0] page, input logic restart);
		int        gap;
		prfl_req_t req;
		gap = 0;
		if ($urandom_range(99) < sender_idle_pct)
			gap = $urandom_range(6, 1);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		req.page_number = page;
		req.restart = restart;
		@(negedge clk);
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// apb write followed by a read back of the same register
	task automatic write_register(input logic idx, input logic [31:0] value);
		logic [31:0] readback;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_POLICY)
			policy_shadow = value[0];
		else
			frame_count_shadow = value[FRAMES_W-1:0];
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		if (idx == REG_POLICY && readback[0] !== policy_shadow)
			flag_error("policy_mode read back", 32'(readback[0]), 32'(policy_shadow));
		if (idx == REG_FRAMES && readback[FRAMES_W-1:0] !== frame_count_shadow)
			flag_error("frames_in_use read back", 32'(readback[FRAMES_W-1:0]),
				32'(frame_count_shadow));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// set both registers once the block is idle; unused bits get noise
	task automatic reconfigure(input logic policy, input logic [FRAMES_W-1:0] frames);
		logic [31:0] policy_word;
		logic [31:0] frames_word;
		policy_word = $urandom;
		policy_word[0] = policy;
		frames_word = $urandom;
		frames_word[FRAMES_W-1:0] = frames;
		drain_results();
		write_register(REG_POLICY, policy_word);
		write_register(REG_FRAMES, frames_word);
	endtask

	task automatic test_fifo_replacement();
		reconfigure(POLICY_FIFO, 4'd3);
		send_reference(8'h00, 1'b1);
		send_reference(8'hff, 1'b0);
		send_reference(8'h00, 1'b0);
		send_reference(8'h80, 1'b0);
		send_reference(8'h01, 1'b0);
		send_reference(8'hff, 1'b0);
	endtask

	// hits move to the front; a restart on a resident page still faults
	task automatic test_lru_replacement();
		reconfigure(POLICY_LRU, 4'd3);
		send_reference(8'h0a, 1'b1);
		send_reference(8'h14, 1'b0);
		send_reference(8'h1e, 1'b0);
		send_reference(8'h0a, 1'b0);
		send_reference(8'h28, 1'b0);
		send_reference(8'h0a, 1'b1);
	endtask

	// zero acts as one frame, values above the built count act as the maximum
	task automatic test_frame_count_limits();
		int p;
		reconfigure(POLICY_FIFO, 4'd0);
		send_reference(8'h05, 1'b1);
		send_reference(8'h06, 1'b0);
		send_reference(8'h06, 1'b0);
		reconfigure(POLICY_LRU, 4'd15);
		send_reference(8'h01, 1'b1);
		for (p = 2; p <= 9; p++)
			send_reference(PAGE_BITS'(p), 1'b0);
	endtask

	// pages left beyond a shrunk list reappear as duplicates when it grows
	task automatic test_stale_duplicates();
		reconfigure(POLICY_FIFO, 4'd2);
		send_reference(8'h04, 1'b0);
		reconfigure(POLICY_LRU, 4'd8);
		send_reference(8'h04, 1'b0);
		send_reference(8'h04, 1'b0);
	endtask

	// random references, mostly within a small working set, settings rotate
	task automatic test_random_traffic(input int items, input int idle_pct);
		int                   n;
		int                   setting;
		int                   span;
		logic [PAGE_BITS-1:0] hot_base;
		logic [PAGE_BITS-1:0] page;
		logic                 restart;
		sender_idle_pct = idle_pct;
		setting = $urandom_range(5);
		span = 4;
		hot_base = '0;
		for (n = 0; n < items; n++) begin
			if (n % 90 == 0) begin
				case (setting % 6)
					0: reconfigure(POLICY_FIFO, 4'd1);
					1: reconfigure(POLICY_LRU, 4'd8);
					2: reconfigure(POLICY_FIFO, 4'd8);
					3: reconfigure(POLICY_LRU, 4'd1);
					4: reconfigure(POLICY_LRU, FRAMES_W'($urandom_range(7, 2)));
					default: reconfigure(1'($urandom_range(1)),
						FRAMES_W'($urandom_range(15)));
				endcase
				setting++;
				hot_base = PAGE_BITS'($urandom);
				span = $urandom_range(11, 2);
			end
			restart = ($urandom_range(99) < 3);
			if ($urandom_range(99) < 75)
				page = hot_base + PAGE_BITS'($urandom_range(span));
			else
				page = PAGE_BITS'($urandom);
			send_reference(page, restart);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		sender_idle_pct = 35;
		test_fifo_replacement();
		test_lru_replacement();
		test_frame_count_limits();
		test_stale_duplicates();
		test_random_traffic(530, 35);
		test_random_traffic(530, 57);
		test_random_traffic(540, 0);

		// let the last results land, then look for leftovers
		drain_results();
		repeat (4) @(posedge clk);
		if (expected_results.size() != 0)
			flag_error("results never returned", expected_results.size(), 0);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/prfl_pkg.sv
design/prfl_regs.sv
design/prfl_datapath.sv
design/prfl_ctrl.sv
design/page_replacement_fifo_lru.sv
tb/page_replacement_fifo_lru_tb.sv
